@@ rtl/rss_pkg.sv @@
`timescale 1ns / 1ps

package rss_pkg;

  // Fixed field widths of the item channels
  localparam int FUNC_BITS = 2;
  localparam int POS_BITS  = 11;
  localparam int DATA_BITS = 32;

  // Defaults for the top-level parameters
  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_LEVELS     = 11;
  localparam int DEF_VALUE_BITS = 32;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_QRY_A,
    ST_QRY_B,
    ST_QRY_C,
    ST_QRY_OUT
  } state_t;

endpackage

@@ rtl/rss_req_if.sv @@
`timescale 1ns / 1ps

interface rss_req_if import rss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_BITS-1:0] func;
  logic [POS_BITS-1:0]  left_end;
  logic [POS_BITS-1:0]  right_end;
  logic [DATA_BITS-1:0] value;

  modport source (output valid, output func, output left_end, output right_end,
                  output value, input ready);
  modport sink (input valid, input func, input left_end, input right_end,
                input value, output ready);
endinterface

@@ rtl/rss_rsp_if.sv @@
`timescale 1ns / 1ps

interface rss_rsp_if import rss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] spread;
  logic [DATA_BITS-1:0] range_max;
  logic [DATA_BITS-1:0] range_min;
  logic                 range_error;

  modport source (output valid, output spread, output range_max, output range_min,
                  output range_error, input ready);
  modport sink (input valid, input spread, input range_max, input range_min,
                input range_error, output ready);
endinterface

@@ rtl/range_spread_sparse_table.sv @@
`timescale 1ns / 1ps

// Range max/min/spread over an appended sequence, kept as two sparse tables.
//
// req channel: one transaction per command. func selects append (value goes to
//   the next position), range query (1-based inclusive left_end..right_end) or
//   clear (count drops to zero). The unused func code is taken and ignored.
// rsp channel: one transaction per query only, carrying range_max, range_min,
//   spread = max - min and range_error. A bad range (left_end of zero,
//   reversed, or past the stored count) returns range_error with zero data.
// Timing: req is taken only in the idle state, one command at a time.
//   Clear stays in idle. Append writes level 0, then walks the n upper levels
//   filled, n = min(LEVELS-1, floor(log2(count))): one read-modify-write per
//   level, set by the single read port of each table memory. A query steps
//   through QRY_A, QRY_B, QRY_C and QRY_OUT (two reads on the same port plus
//   compare and subtract); a bad range skips the reads, straight to QRY_OUT.
// Stalls: the result sits in an output register; while rsp is stalled the
//   block still takes appends and clears, and a query waits in its last step
//   until the register frees.
// Reset: the count and all control clear at once; no table sweep is needed,
//   since a valid query reads only entries written since the last clear.
module range_spread_sparse_table import rss_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int LEVELS     = DEF_LEVELS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic       clk,
  input logic       rst,
  rss_req_if.sink   req,
  rss_rsp_if.source rsp
);

  // Stored value width: the input field carries at most DATA_BITS bits
  localparam int SW    = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
  localparam int DEPTH = CAPACITY * LEVELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int LW    = $clog2(LEVELS + 1);

  state_t state, state_next;

  // Table memories: entry (pos, lvl) at (pos - 1) * LEVELS + lvl
  logic [SW-1:0] max_mem [DEPTH];
  logic [SW-1:0] min_mem [DEPTH];
  logic [SW-1:0] rd_max, rd_min;
  logic          mem_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [SW-1:0] wr_max, wr_min;

  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [LW-1:0] lvl;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [SW-1:0] held_max, held_min;
  logic [SW-1:0] new_max, new_min;
  logic          issue;
  logic [AW-1:0] app_rd_addr;

  logic [POS_BITS-1:0] q_lo, q_hi;
  logic [LW-1:0]       q_k;
  logic                q_err;
  logic [SW-1:0]       a_max, a_min;
  logic [SW-1:0]       res_max, res_min;

  logic                accept;
  logic                req_bad;
  logic [POS_BITS-1:0] req_len;
  logic [3:0]          len_log;
  logic [LW-1:0]       req_k;
  logic [POS_BITS-1:0] q_second0;

  logic                 rsp_valid;
  logic [DATA_BITS-1:0] rsp_spread, rsp_max, rsp_min;
  logic                 rsp_err;
  logic                 rsp_load;

  assign accept = req.valid && req.ready;

  // Query range check and floor(log2(length)), clamped to the top level
  assign req_bad = (req.left_end == '0) || (req.left_end > req.right_end) ||
                   (32'(req.right_end) > 32'(count));
  assign req_len = req.right_end - req.left_end + POS_BITS'(1);

  always_comb begin
    len_log = '0;
    for (int i = 0; i < POS_BITS; i++) begin
      if (req_len[i]) len_log = 4'(i);
    end
    req_k = (32'(len_log) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(len_log);
  end

  // Append level walk: level lvl exists while 2^lvl <= pos
  assign issue       = (32'(lvl) < LEVELS) && ((pos >> lvl) != '0);
  assign app_rd_addr = AW'(pos - (CW'(1) << lvl)) * AW'(LEVELS) + AW'(lvl - LW'(1));
  assign new_max     = (rd_max > held_max) ? rd_max : held_max;
  assign new_min     = (rd_min < held_min) ? rd_min : held_min;

  // Second block of a query starts at hi - 2^k + 1; keep its zero-based index
  assign q_second0 = q_hi - (POS_BITS'(1) << q_k);

  always_comb begin
    state_next = state;
    req.ready  = (state == ST_IDLE);
    mem_we     = 1'b0;
    wr_addr    = '0;
    wr_max     = '0;
    wr_min     = '0;
    rd_addr    = '0;
    rsp_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_APPEND && count < CW'(CAPACITY)) begin
            // Level 0 holds the value itself
            mem_we     = 1'b1;
            wr_addr    = AW'(count) * AW'(LEVELS);
            wr_max     = req.value[SW-1:0];
            wr_min     = req.value[SW-1:0];
            state_next = ST_APPEND;
          end else if (req.func == FUNC_QUERY) begin
            state_next = req_bad ? ST_QRY_OUT : ST_QRY_A;
          end
        end
      end
      ST_APPEND: begin
        // Retire the level read last cycle; its entry sits one above the read
        if (pend) begin
          mem_we  = 1'b1;
          wr_addr = pend_addr + AW'(1);
          wr_max  = new_max;
          wr_min  = new_min;
        end
        if (issue) begin
          rd_addr = app_rd_addr;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_QRY_A: begin
        rd_addr    = AW'(q_lo - POS_BITS'(1)) * AW'(LEVELS) + AW'(q_k);
        state_next = ST_QRY_B;
      end
      ST_QRY_B: begin
        rd_addr    = AW'(q_second0) * AW'(LEVELS) + AW'(q_k);
        state_next = ST_QRY_C;
      end
      ST_QRY_C: begin
        state_next = ST_QRY_OUT;
      end
      ST_QRY_OUT: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table memories: one write and one registered read port each
  always_ff @(posedge clk) begin
    if (mem_we) begin
      max_mem[wr_addr] <= wr_max;
      min_mem[wr_addr] <= wr_min;
    end
    rd_max <= max_mem[rd_addr];
    rd_min <= min_mem[rd_addr];
  end

  // Count and append walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else if (state == ST_IDLE) begin
      pend <= 1'b0;
      if (accept && req.func == FUNC_APPEND && count < CW'(CAPACITY)) begin
        count <= count + CW'(1);
      end else if (accept && req.func == FUNC_CLEAR) begin
        count <= '0;
      end
    end else if (state == ST_APPEND) begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      pos      <= count + CW'(1);
      lvl      <= LW'(1);
      held_max <= req.value[SW-1:0];
      held_min <= req.value[SW-1:0];
    end else if (state == ST_APPEND) begin
      if (pend) begin
        held_max <= new_max;
        held_min <= new_min;
      end
      if (issue) begin
        lvl       <= lvl + LW'(1);
        pend_addr <= app_rd_addr;
      end
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q_lo    <= req.left_end;
        q_hi    <= req.right_end;
        q_k     <= req_k;
        q_err   <= req_bad;
        res_max <= '0;
        res_min <= '0;
      end
      ST_QRY_B: begin
        a_max <= rd_max;
        a_min <= rd_min;
      end
      ST_QRY_C: begin
        res_max <= (rd_max > a_max) ? rd_max : a_max;
        res_min <= (rd_min < a_min) ? rd_min : a_min;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_spread <= DATA_BITS'(res_max - res_min);
      rsp_max    <= DATA_BITS'(res_max);
      rsp_min    <= DATA_BITS'(res_min);
      rsp_err    <= q_err;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.spread      = rsp_spread;
  assign rsp.range_max   = rsp_max;
  assign rsp.range_min   = rsp_min;
  assign rsp.range_error = rsp_err;

endmodule

@@ dv/range_spread_sparse_table_tb.sv @@
`timescale 1ns / 1ps

module range_spread_sparse_table_tb;
  import rss_pkg::*;

  // Block configuration: the defaults of the package, mirrored for the predictor
  localparam int CAPACITY   = DEF_CAPACITY;
  localparam int LEVELS     = DEF_LEVELS;
  localparam int VALUE_BITS = DEF_VALUE_BITS;

  // The fourth func code has no meaning; the block takes it and drops it
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [63:0] VALUE_MASK64 = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [DATA_BITS-1:0] VALUE_MASK = VALUE_MASK64[DATA_BITS-1:0];

  // An append walks at most LEVELS-1 upper levels after writing level 0;
  // allow that and some slack before calling the block quiet
  localparam int SETTLE_CYCLES = LEVELS + 10;

  // Generous run limit in ns, far above the slowest legal run
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;

  localparam int RANDOM_ITEMS = 800;

  typedef struct packed {
    logic [DATA_BITS-1:0] spread;
    logic [DATA_BITS-1:0] range_max;
    logic [DATA_BITS-1:0] range_min;
    logic                 range_error;
  } range_result_t;

  logic clk;
  logic rst;

  rss_req_if req_ch ();
  rss_rsp_if rsp_ch ();

  range_spread_sparse_table #(
    .CAPACITY  (CAPACITY),
    .LEVELS    (LEVELS),
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the stored count and both sparse tables.
  // Entry (pos, lvl) covers positions pos .. pos + 2^lvl - 1, 1-based.
  // ---------------------------------------------------------------------------
  logic [DATA_BITS-1:0] max_tab [CAPACITY*LEVELS];
  logic [DATA_BITS-1:0] min_tab [CAPACITY*LEVELS];
  int                   stored_count;

  // Results the block still owes, oldest first
  range_result_t        pending_results [$];

  // Run bookkeeping
  int  n_fail;
  int  n_checked;
  int  n_append;
  int  n_dropped;
  int  n_query;
  int  n_bad_range;
  int  n_clear;
  int  n_ignored;

  // Stimulus-side controls shared by the tests and the response driver
  bit  idle_enable;
  int  rsp_hold_left;
  int  gen_count;     // count as seen by the stimulus, for building ranges

  // ---------------------------------------------------------------------------
  // Clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int tab_idx(int pos, int lvl);
    return (pos - 1) * LEVELS + lvl;
  endfunction

  function automatic int floor_log2(int x);
    int k;
    k = 0;
    while (x > 1) begin
      x = x >> 1;
      k++;
    end
    return k;
  endfunction

  // Store the next value and rebuild every entry that ends at the new position
  function automatic void store_append(logic [DATA_BITS-1:0] v);
    int p;
    int len;
    int half;
    int i;
    logic [DATA_BITS-1:0] a;
    logic [DATA_BITS-1:0] b;
    if (stored_count >= CAPACITY) begin
      n_dropped++;
      return;
    end
    p = stored_count + 1;
    stored_count = p;
    max_tab[tab_idx(p, 0)] = v;
    min_tab[tab_idx(p, 0)] = v;
    for (int j = 1; j < LEVELS; j++) begin
      len = 1 << j;
      if (len > p) break;
      half = len >> 1;
      i = p - len + 1;
      a = max_tab[tab_idx(i, j - 1)];
      b = max_tab[tab_idx(i + half, j - 1)];
      max_tab[tab_idx(i, j)] = (a > b) ? a : b;
      a = min_tab[tab_idx(i, j - 1)];
      b = min_tab[tab_idx(i + half, j - 1)];
      min_tab[tab_idx(i, j)] = (a < b) ? a : b;
    end
  endfunction

  // Combine two overlapping power-of-two blocks that cover [lo, hi]
  function automatic range_result_t range_query(int lo, int hi);
    range_result_t r;
    int k;
    int second;
    logic [DATA_BITS-1:0] a;
    logic [DATA_BITS-1:0] b;
    r = '0;
    if (lo < 1 || lo > hi || hi > stored_count) begin
      r.range_error = 1'b1;
      return r;
    end
    k = floor_log2(hi - lo + 1);
    if (k >= LEVELS) k = LEVELS - 1;
    second = hi - (1 << k) + 1;
    a = max_tab[tab_idx(lo, k)];
    b = max_tab[tab_idx(second, k)];
    r.range_max = (a > b) ? a : b;
    a = min_tab[tab_idx(lo, k)];
    b = min_tab[tab_idx(second, k)];
    r.range_min = (a < b) ? a : b;
    r.spread = r.range_max - r.range_min;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and checker. At each rising edge, first check a response
  // transaction against the oldest pending result, then feed an accepted
  // request transaction to the predictor. A request taken at this edge can
  // never answer at the same edge, so the order inside the block is safe.
  // ---------------------------------------------------------------------------
  initial begin
    stored_count = 0;
    n_fail       = 0;
    n_checked    = 0;
    n_append     = 0;
    n_dropped    = 0;
    n_query      = 0;
    n_bad_range  = 0;
    n_clear      = 0;
    n_ignored    = 0;
  end

  always @(posedge clk) begin : result_check
    range_result_t want;
    range_result_t got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.spread      = rsp_ch.spread;
        got.range_max   = rsp_ch.range_max;
        got.range_min   = rsp_ch.range_min;
        got.range_error = rsp_ch.range_error;
        if (pending_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] unexpected result: spread=%h max=%h min=%h err=%b",
                     $realtime, got.spread, got.range_max, got.range_min,
                     got.range_error);
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("[%0t] result mismatch: expected spread=%h max=%h min=%h err=%b",
                       $realtime, want.spread, want.range_max, want.range_min,
                       want.range_error);
              $display("[%0t]   got spread=%h max=%h min=%h err=%b",
                       $realtime, got.spread, got.range_max, got.range_min,
                       got.range_error);
            end
          end
        end
      end

      if (req_ch.valid && req_ch.ready) begin
        case (req_ch.func)
          FUNC_APPEND: begin
            n_append++;
            store_append(req_ch.value & VALUE_MASK);
          end
          FUNC_QUERY: begin
            want = range_query(int'(req_ch.left_end), int'(req_ch.right_end));
            if (want.range_error) n_bad_range++;
            n_query++;
            pending_results.push_back(want);
          end
          FUNC_CLEAR: begin
            n_clear++;
            stored_count = 0;
          end
          default: n_ignored++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values: many ties from a small alphabet, the extremes, and full-width noise
  function automatic logic [DATA_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return DATA_BITS'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: drive ready at the falling edge. A long hold requested by a
  // test is counted down here; otherwise stall at random while idling is on.
  // ---------------------------------------------------------------------------
  initial begin : rsp_driver
    int stall_left;
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rsp_hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = idle_enable ? pick_gap() : 0;
        if (stall_left > 0) begin
          rsp_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Every change happens at a falling edge; valid stays high
  // from one transaction straight into the next when there is no gap.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [FUNC_BITS-1:0] f, input int lo, input int hi,
                          input logic [DATA_BITS-1:0] v);
    int gap;
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.func      <= f;
    req_ch.left_end  <= POS_BITS'(lo);
    req_ch.right_end <= POS_BITS'(hi);
    req_ch.value     <= v;
    // hold the transaction until the block takes it
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    case (f)
      FUNC_APPEND: if (gen_count < CAPACITY) gen_count++;
      FUNC_CLEAR:  gen_count = 0;
      default: ;
    endcase
  endtask

  task automatic send_append(input logic [DATA_BITS-1:0] v);
    send_cmd(FUNC_APPEND, $urandom_range(0, CAPACITY), $urandom_range(0, CAPACITY), v);
  endtask

  task automatic send_query(input int lo, input int hi);
    send_cmd(FUNC_QUERY, lo, hi, $urandom);
  endtask

  // Pick a range that lies wholly inside the stored sequence; now and then
  // use an exact power-of-two length so both blocks coincide
  task automatic send_good_query();
    int lo;
    int hi;
    int k;
    lo = $urandom_range(1, gen_count);
    if ($urandom_range(0, 3) == 0) begin
      k = floor_log2(gen_count - lo + 1);
      k = $urandom_range(0, k);
      hi = lo + (1 << k) - 1;
    end else begin
      hi = $urandom_range(lo, gen_count);
    end
    send_query(lo, hi);
  endtask

  // Left end of zero, reversed, or past the stored count
  task automatic send_bad_query();
    int lo;
    case ($urandom_range(0, 2))
      0: send_query(0, $urandom_range(0, CAPACITY));
      1: begin
        lo = $urandom_range(2, CAPACITY);
        send_query(lo, $urandom_range(1, lo - 1));
      end
      default: begin
        if (gen_count >= CAPACITY) send_query(0, 0);
        else send_query($urandom_range(1, gen_count + 1),
                        $urandom_range(gen_count + 1, CAPACITY));
      end
    endcase
  endtask

  // Drop valid, let every owed result arrive, then let a trailing append
  // finish its level walk
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, each func code and each bad-range case on a short sequence
  task automatic test_directed();
    send_query(1, 1);                       // empty store
    send_query(0, 0);
    send_cmd(FUNC_UNUSED, CAPACITY, CAPACITY, '1);
    send_append('0);
    send_append('1);
    send_append(32'h0000_0001);
    send_append(32'h8000_0000);
    send_append(32'h7FFF_FFFF);
    send_append(32'h0000_0005);
    send_append(32'h0000_0005);
    send_append(32'hFFFF_FFFE);
    send_query(1, 8);
    send_query(1, 1);
    send_query(2, 2);
    send_query(3, 5);
    send_query(6, 7);                       // tie of equal values
    send_query(1, 2);
    send_query(5, 2);                       // reversed
    send_query(0, 3);                       // left end of zero
    send_query(1, 9);                       // past the count
    send_query(8, 8);
    send_cmd(FUNC_CLEAR, 0, 0, '0);
    send_query(1, 1);                       // cleared store
    send_append(32'hA5A5_A5A5);
    send_query(1, 1);
  endtask

  // Fill to capacity, query across the whole store, and drop appends past it
  task automatic test_full_store();
    send_cmd(FUNC_CLEAR, 0, 0, '0);
    for (int i = 0; i < CAPACITY; i++) send_append(pick_value());
    send_query(1, CAPACITY);
    send_query(CAPACITY, CAPACITY);
    send_query(1, 1);
    send_query(CAPACITY / 2 + 1, CAPACITY);
    send_query(1, CAPACITY - 1);
    send_query(2, CAPACITY);
    send_query(CAPACITY, 1);
    repeat (4) send_good_query();
    send_append('1);                        // dropped
    send_append('0);                        // dropped
    send_query(1, CAPACITY);
    send_query(CAPACITY - 24, CAPACITY);
    send_cmd(FUNC_CLEAR, 0, 0, '0);
    send_query(1, CAPACITY);
  endtask

  // Hold the response side off for a long stretch while requests keep coming:
  // the output register fills, the next query parks in its last step and the
  // request side stalls until the hold runs out
  task automatic test_backpressure();
    send_cmd(FUNC_CLEAR, 0, 0, '0);
    repeat (16) send_append(pick_value());
    wait_drained();
    idle_enable = 1'b0;
    @(negedge clk);
    rsp_hold_left = 300;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_append(pick_value());
      else send_good_query();
    end
    idle_enable = 1'b1;
    wait_drained();
  endtask

  // Mostly well-formed traffic: clears, bursts of appends and queries inside
  // the stored range, with bad ranges and raw noise mixed in
  task automatic test_random_sequences(input int n_items);
    int sent;
    int r;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      // advance into and out of stretches with no idling at all
      if ($urandom_range(0, 199) == 0) idle_enable = !idle_enable;
      // now and then pause until the block has answered everything
      if ($urandom_range(0, 149) == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_cmd(2'($urandom_range(0, 3)), $urandom_range(0, CAPACITY),
                 $urandom_range(0, CAPACITY), $urandom);
        sent++;
      end else if (r < 12) begin
        send_cmd(FUNC_CLEAR, $urandom_range(0, CAPACITY), $urandom_range(0, CAPACITY),
                 $urandom);
        sent++;
      end else if (r < 50) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
        repeat (burst) send_append(pick_value());
        sent += burst;
      end else begin
        if (gen_count > 0 && $urandom_range(0, 99) < 85) send_good_query();
        else send_bad_query();
        sent++;
      end
    end
    idle_enable = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    idle_enable      = 1'b1;
    rsp_hold_left    = 0;
    gen_count        = 0;
    req_ch.valid     = 1'b0;
    req_ch.func      = FUNC_APPEND;
    req_ch.left_end  = '0;
    req_ch.right_end = '0;
    req_ch.value     = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    wait_drained();
    test_full_store();
    wait_drained();
    test_backpressure();
    test_random_sequences(RANDOM_ITEMS);
    wait_drained();

    if (pending_results.size() != 0) n_fail++;

    $display("covered %0d appends (%0d dropped at full store), %0d clears, %0d ignored codes",
             n_append, n_dropped, n_clear, n_ignored);
    $display("covered %0d queries (%0d bad ranges), %0d results checked, %0d failures",
             n_query, n_bad_range, n_checked, n_fail);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
